// ===== design/cpso_pkg.sv =====
// ----------------------------------------------------------------------------
// cpso_pkg
// Shared types and codes for the convex polygon separating axis overlap block.
// ----------------------------------------------------------------------------
package cpso_pkg;

   localparam int DEF_MAX_VERTS  = 16;
   localparam int DEF_COORD_BITS = 16;

   // datapath pipeline operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
   localparam logic [OP_W-1:0] OP_EDGE0  = 3'd1;  // latch edge start vertex
   localparam logic [OP_W-1:0] OP_EDGE1  = 3'd2;  // edge end vertex, form axis
   localparam logic [OP_W-1:0] OP_PROJ_A = 3'd3;  // project vertex of edge owner
   localparam logic [OP_W-1:0] OP_PROJ_B = 3'd4;  // project vertex of other polygon
   localparam logic [OP_W-1:0] OP_CHECK  = 3'd5;  // compare the two ranges

   typedef struct packed {
      logic            load;       // store the accepted request vertex
      logic            start;      // clear the separation flag
      logic            clear;      // clear counts and overflow flag
      logic [OP_W-1:0] op;
      logic            first;      // first vertex of a projection range
      logic            final_chk;  // last range check of the test
      logic            sel;        // 0 = first polygon store, 1 = second
   } dp_cmd_type;

   typedef struct packed {
      logic done;      // final check has gone through
      logic sep;       // a separating axis was found
      logic overflow;  // a vertex was dropped since the last test
   } dp_status_type;

endpackage

// ===== design/cpso_dp.sv =====
// ----------------------------------------------------------------------------
// cpso_dp
// Vertex stores, axis forming, projection multipliers and range tracking.
// ----------------------------------------------------------------------------
module cpso_dp
   import cpso_pkg::*;
#(
   parameter int MAX_VERTS  = DEF_MAX_VERTS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load_sel,
   input  logic [COORD_BITS-1:0]                 load_x,
   input  logic [COORD_BITS-1:0]                 load_y,
   input  dp_cmd_type                            cmd,
   input  logic [$clog2(MAX_VERTS)-1:0]          rd_addr,
   output logic [$clog2(MAX_VERTS+1)-1:0]        first_count,
   output logic [$clog2(MAX_VERTS+1)-1:0]        second_count,
   output dp_status_type                         status
);

   localparam int C  = COORD_BITS;
   localparam int AW = $clog2(MAX_VERTS);
   localparam int CW = $clog2(MAX_VERTS + 1);
   localparam int PW = 2 * C + 2;
   localparam int XW = C + 1;
   localparam int MW = 2 * C + 1;

   logic [2*C-1:0] first_mem  [MAX_VERTS];
   logic [2*C-1:0] second_mem [MAX_VERTS];

   logic [CW-1:0] first_count_ff, first_count_in;
   logic [CW-1:0] second_count_ff, second_count_in;
   logic          overflow_ff, overflow_in;
   logic          first_full, second_full;

   logic [2*C-1:0] rd_first_ff, rd_second_ff;
   logic [OP_W-1:0] op_d_ff, op_m_ff;
   logic            first_d_ff, first_m_ff;
   logic            final_d_ff, final_m_ff;
   logic            sel_d_ff;

   logic signed [C-1:0]   vx, vy;
   logic signed [C-1:0]   p0x_ff, p0y_ff;
   logic signed [C:0]     ax_ff, ay_ff;
   logic signed [2*C:0]   mx_ff, my_ff;
   logic signed [PW-1:0]  q;
   logic signed [PW-1:0]  lo1_ff, hi1_ff, lo2_ff, hi2_ff;
   logic                  done_ff, sep_ff, sep_in;

   assign first_full  = (first_count_ff  >= CW'(MAX_VERTS));
   assign second_full = (second_count_ff >= CW'(MAX_VERTS));

   // vertex loading and count bookkeeping
   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      overflow_in     = overflow_ff;
      if (cmd.clear) begin
         first_count_in  = '0;
         second_count_in = '0;
         overflow_in     = 1'b0;
      end else if (cmd.load) begin
         if (!load_sel) begin
            if (first_full) overflow_in = 1'b1;
            else first_count_in = first_count_ff + CW'(1);
         end else begin
            if (second_full) overflow_in = 1'b1;
            else second_count_in = second_count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !load_sel && !first_full) begin
         first_mem[first_count_ff[AW-1:0]] <= {load_y, load_x};
      end
      if (cmd.load && load_sel && !second_full) begin
         second_mem[second_count_ff[AW-1:0]] <= {load_y, load_x};
      end
      rd_first_ff  <= first_mem[rd_addr];
      rd_second_ff <= second_mem[rd_addr];
   end

   // read data stage
   assign vx = sel_d_ff ? rd_second_ff[C-1:0]   : rd_first_ff[C-1:0];
   assign vy = sel_d_ff ? rd_second_ff[2*C-1:C] : rd_first_ff[2*C-1:C];

   always_ff @(posedge clock) begin
      unique case (op_d_ff)
         OP_EDGE0: begin
            p0x_ff <= vx;
            p0y_ff <= vy;
         end
         OP_EDGE1: begin
            // edge normal (-dy, dx)
            ax_ff <= XW'(p0y_ff) - XW'(vy);
            ay_ff <= XW'(vx) - XW'(p0x_ff);
         end
         OP_PROJ_A, OP_PROJ_B: begin
            mx_ff <= MW'(vx) * MW'(ax_ff);
            my_ff <= MW'(vy) * MW'(ay_ff);
         end
         default: begin
         end
      endcase
   end

   // product stage: sum, then track range or check
   assign q = PW'(mx_ff) + PW'(my_ff);

   always_ff @(posedge clock) begin
      if (op_m_ff == OP_PROJ_A) begin
         if (first_m_ff || q < lo1_ff) lo1_ff <= q;
         if (first_m_ff || q > hi1_ff) hi1_ff <= q;
      end
      if (op_m_ff == OP_PROJ_B) begin
         if (first_m_ff || q < lo2_ff) lo2_ff <= q;
         if (first_m_ff || q > hi2_ff) hi2_ff <= q;
      end
   end

   always_comb begin
      sep_in = sep_ff;
      if (cmd.start) sep_in = 1'b0;
      else if (op_m_ff == OP_CHECK && !(hi2_ff >= lo1_ff && hi1_ff >= lo2_ff)) sep_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
         op_d_ff         <= OP_NONE;
         op_m_ff         <= OP_NONE;
         first_d_ff      <= 1'b0;
         first_m_ff      <= 1'b0;
         final_d_ff      <= 1'b0;
         final_m_ff      <= 1'b0;
         sel_d_ff        <= 1'b0;
         done_ff         <= 1'b0;
         sep_ff          <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         overflow_ff     <= overflow_in;
         op_d_ff         <= cmd.op;
         op_m_ff         <= op_d_ff;
         first_d_ff      <= cmd.first;
         first_m_ff      <= first_d_ff;
         final_d_ff      <= cmd.final_chk;
         final_m_ff      <= final_d_ff;
         sel_d_ff        <= cmd.sel;
         done_ff         <= (op_m_ff == OP_CHECK) && final_m_ff;
         sep_ff          <= sep_in;
      end
   end

   assign first_count     = first_count_ff;
   assign second_count    = second_count_ff;
   assign status.done     = done_ff;
   assign status.sep      = sep_ff;
   assign status.overflow = overflow_ff;

endmodule

// ===== design/cpso_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpso_ctrl
// Sequencer: loads vertices, walks every edge of both polygons, holds result.
// ----------------------------------------------------------------------------
module cpso_ctrl
   import cpso_pkg::*;
#(
   parameter int MAX_VERTS = DEF_MAX_VERTS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic                                  rsp_overlap,
   output logic                                  rsp_overflow,
   input  logic [$clog2(MAX_VERTS+1)-1:0]        first_count,
   input  logic [$clog2(MAX_VERTS+1)-1:0]        second_count,
   input  dp_status_type                         status,
   output dp_cmd_type                            cmd,
   output logic [$clog2(MAX_VERTS)-1:0]          rd_addr
);

   localparam int AW = $clog2(MAX_VERTS);
   localparam int CW = $clog2(MAX_VERTS + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_RUN    = 3'd2;
   localparam logic [2:0] S_WAIT   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   localparam logic [2:0] PH_EDGE0 = 3'd0;
   localparam logic [2:0] PH_EDGE1 = 3'd1;
   localparam logic [2:0] PH_PA    = 3'd2;
   localparam logic [2:0] PH_PB    = 3'd3;
   localparam logic [2:0] PH_CHECK = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    phase_ff, phase_in;
   logic          pass_ff, pass_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] k_ff, k_in;
   logic          result_ff, result_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_overlap_ff, rsp_overflow_ff;
   logic          rsp_load;
   logic          req_accept;

   logic [CW-1:0] na_cur, nb_cur;
   logic          edge_last, k_last_a, k_last_b;
   logic [AW-1:0] j_idx;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);

   // pass 0 tests the edges of the first polygon, pass 1 those of the second
   assign na_cur    = pass_ff ? second_count : first_count;
   assign nb_cur    = pass_ff ? first_count  : second_count;
   assign edge_last = (CW'(i_ff) + CW'(1)) == na_cur;
   assign k_last_a  = (CW'(k_ff) + CW'(1)) == na_cur;
   assign k_last_b  = (CW'(k_ff) + CW'(1)) == nb_cur;
   assign j_idx     = edge_last ? '0 : i_ff + AW'(1);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      pass_in       = pass_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      result_in     = result_ff;
      cmd           = '0;
      cmd.op        = OP_NONE;
      rd_addr       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd.load = 1'b1;
               if (req_tlast) state_in = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            if (first_count == '0 || second_count == '0) begin
               // no axis at all overlaps; one empty range never meets
               result_in = (first_count == '0) && (second_count == '0);
               state_in  = S_FINISH;
            end else begin
               pass_in  = 1'b0;
               i_in     = '0;
               k_in     = '0;
               phase_in = PH_EDGE0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            unique case (phase_ff)
               PH_EDGE0: begin
                  cmd.op   = OP_EDGE0;
                  cmd.sel  = pass_ff;
                  rd_addr  = i_ff;
                  phase_in = PH_EDGE1;
               end
               PH_EDGE1: begin
                  cmd.op   = OP_EDGE1;
                  cmd.sel  = pass_ff;
                  rd_addr  = j_idx;
                  k_in     = '0;
                  phase_in = PH_PA;
               end
               PH_PA: begin
                  cmd.op    = OP_PROJ_A;
                  cmd.sel   = pass_ff;
                  cmd.first = (k_ff == '0);
                  rd_addr   = k_ff;
                  if (k_last_a) begin
                     k_in     = '0;
                     phase_in = PH_PB;
                  end else begin
                     k_in = k_ff + AW'(1);
                  end
               end
               PH_PB: begin
                  cmd.op    = OP_PROJ_B;
                  cmd.sel   = !pass_ff;
                  cmd.first = (k_ff == '0);
                  rd_addr   = k_ff;
                  if (k_last_b) begin
                     k_in     = '0;
                     phase_in = PH_CHECK;
                  end else begin
                     k_in = k_ff + AW'(1);
                  end
               end
               PH_CHECK: begin
                  cmd.op        = OP_CHECK;
                  cmd.final_chk = pass_ff && edge_last;
                  phase_in      = PH_EDGE0;
                  if (!edge_last) begin
                     i_in = i_ff + AW'(1);
                  end else if (!pass_ff) begin
                     pass_in = 1'b1;
                     i_in    = '0;
                  end else begin
                     state_in = S_WAIT;
                  end
               end
               default: begin
                  phase_in = PH_EDGE0;
               end
            endcase
         end
         S_WAIT: begin
            if (status.done) begin
               result_in = !status.sep;
               state_in  = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_load) begin
               cmd.clear = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_EDGE0;
         pass_ff      <= 1'b0;
         i_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pass_ff      <= pass_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      if (rsp_load) begin
         rsp_overlap_ff  <= result_ff;
         rsp_overflow_ff <= status.overflow;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_overlap  = rsp_overlap_ff;
   assign rsp_overflow = rsp_overflow_ff;

   // the final check can only come back while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.done |-> state_ff == S_WAIT)
      else $error("range check finished outside the wait state");

   // a request marked last starts a test in the next cycle
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> state_ff == S_START)
      else $error("last request did not start a test");

   // a loaded result is presented with the sequencer back in idle, ready for requests
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("result load did not reach the output register");

   // no request is accepted while a test is in progress
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN || state_ff == S_WAIT) |-> !req_tready)
      else $error("request accepted during a test");

endmodule

// ===== design/convex_polygon_sat_overlap.sv =====
// ----------------------------------------------------------------------------
// convex_polygon_sat_overlap
// Separating axis overlap test of two convex polygons loaded vertex by vertex.
// ----------------------------------------------------------------------------
//
//   channel  | direction | tdata (low bit up)           | tuser      | tlast
//   req_     | in        | x[COORD_BITS], y[COORD_BITS] | func       | last
//   rsp_     | out       | overlap, zero fill           | overflow   | -
//
// A request without tlast is stored; requests can follow every cycle while no test runs.
// A request with tlast starts the test: with both counts nonzero, the sequencer walks
// every edge of both polygons with one store read a cycle, projecting all vertices;
// with a polygon empty the walk is skipped and the result is decided directly.
// Requests are held off during the test; a finished result waits in the output
// register while the next vertices load. Reset is synchronous and clears counts.
//
module convex_polygon_sat_overlap
   import cpso_pkg::*;
#(
   parameter int MAX_VERTS  = DEF_MAX_VERTS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // x, y
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]        req_tdata,
   // func
   input  logic                                     req_tuser,
   input  logic                                     req_tlast,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // overlap, zero fill
   output logic [7:0]                               rsp_tdata,
   // overflow
   output logic                                     rsp_tuser
);

   localparam int AW = $clog2(MAX_VERTS);
   localparam int CW = $clog2(MAX_VERTS + 1);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] first_count, second_count;
   logic          rsp_overlap;

   cpso_ctrl #(
      .MAX_VERTS (MAX_VERTS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_overlap  (rsp_overlap),
      .rsp_overflow (rsp_tuser),
      .first_count  (first_count),
      .second_count (second_count),
      .status       (status),
      .cmd          (cmd),
      .rd_addr      (rd_addr)
   );

   cpso_dp #(
      .MAX_VERTS  (MAX_VERTS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .load_sel     (req_tuser),
      .load_x       (req_tdata[COORD_BITS-1:0]),
      .load_y       (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .first_count  (first_count),
      .second_count (second_count),
      .status       (status)
   );

   assign rsp_tdata = {7'b0, rsp_overlap};

endmodule
